// ===== sv/erc_pkg.sv =====
// ============================================================================
// erc_pkg
// Shared types, codes and reset constants for the encoder rotation and click
// detector.
// ============================================================================
package erc_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DBNC_W = 8;
  localparam int unsigned DCLK_W = 16;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [POS_W-1:0]  POSITION_TOP_RESET    = 16'd65532;
  localparam logic [DBNC_W-1:0] DEBOUNCE_MS_RESET     = 8'd50;
  localparam logic [DCLK_W-1:0] DOUBLE_CLICK_MS_RESET = 16'd300;

  // register index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_POSITION_TOP    = 2'd0,
    REG_DEBOUNCE_MS     = 2'd1,
    REG_DOUBLE_CLICK_MS = 2'd2,
    REG_UNUSED          = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_POSITION = 2'd0,
    CMD_PRESS    = 2'd1,
    CMD_RELEASE  = 2'd2,
    CMD_SYNC     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_INC    = 3'd1,
    EV_DEC    = 3'd2,
    EV_CLICK  = 3'd3,
    EV_DOUBLE = 3'd4
  } event_t;

  typedef struct packed {
    logic [POS_W-1:0]  position_top;
    logic [DBNC_W-1:0] debounce_ms;
    logic [DCLK_W-1:0] double_click_ms;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  previous_position;
    logic [TIME_W-1:0] last_press_time;
    logic [TIME_W-1:0] last_release_time;
    logic              button_held;
  } state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [POS_W-1:0]  position;
    logic [TIME_W-1:0] time_ms;
    logic              button_level;
  } item_t;

  typedef struct packed {
    event_t            event_res;
    logic [TIME_W-1:0] event_time;
    state_t            state_next;
  } decision_t;

endpackage

// ===== sv/erc_req_if.sv =====
// ============================================================================
// erc_req_if
// Request channel: one encoder event with valid/ready handshake.
// ============================================================================
interface erc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] position;
  logic [31:0] time_ms;
  logic        button_level;

  modport source (output valid, command, position, time_ms, button_level,
                  input ready);
  modport sink   (input valid, command, position, time_ms, button_level,
                  output ready);
endinterface

// ===== sv/erc_res_if.sv =====
// ============================================================================
// erc_res_if
// Result channel: one detected event with valid/ready handshake.
// ============================================================================
interface erc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] event_time;

  modport source (output valid, event_res, event_time, input ready);
  modport sink   (input valid, event_res, event_time, output ready);
endinterface

// ===== sv/erc_cfg.sv =====
// ============================================================================
// erc_cfg
// APB-style register bank: position top, debounce and double-click window.
// ============================================================================
module erc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [erc_pkg::ADDR_W-1:0]  paddr,
  input  logic [erc_pkg::DATA_W-1:0]  pwdata,
  output logic [erc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output erc_pkg::cfg_t               cfg
);

  erc_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = erc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_top    <= erc_pkg::POSITION_TOP_RESET;
      cfg.debounce_ms     <= erc_pkg::DEBOUNCE_MS_RESET;
      cfg.double_click_ms <= erc_pkg::DOUBLE_CLICK_MS_RESET;
    end else if (wr_en) begin
      case (idx)
        erc_pkg::REG_POSITION_TOP:    cfg.position_top    <= pwdata[15:0];
        erc_pkg::REG_DEBOUNCE_MS:     cfg.debounce_ms     <= pwdata[7:0];
        erc_pkg::REG_DOUBLE_CLICK_MS: cfg.double_click_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      erc_pkg::REG_POSITION_TOP:    prdata = {16'd0, cfg.position_top};
      erc_pkg::REG_DEBOUNCE_MS:     prdata = {24'd0, cfg.debounce_ms};
      erc_pkg::REG_DOUBLE_CLICK_MS: prdata = {16'd0, cfg.double_click_ms};
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== sv/erc_decide.sv =====
// ============================================================================
// erc_decide
// Event decision: direction from position compare, debounced click and
// double click, release and sync handling, plus the next state.
// ============================================================================
module erc_decide (
  input  erc_pkg::item_t     item,
  input  erc_pkg::state_t    state,
  input  erc_pkg::cfg_t      cfg,
  output erc_pkg::decision_t dec
);

  logic [erc_pkg::TIME_W-1:0] since_press;
  logic [erc_pkg::TIME_W-1:0] since_release;
  logic                       debounced;
  logic                       is_double;
  erc_pkg::event_t            dir;

  // time differences wrap modulo 2^32
  assign since_press   = item.time_ms - state.last_press_time;
  assign since_release = item.time_ms - state.last_release_time;
  assign debounced = (since_press   > {24'd0, cfg.debounce_ms}) &&
                     (since_release > {24'd0, cfg.debounce_ms});
  assign is_double = since_press < {16'd0, cfg.double_click_ms};

  // wrap cases take priority over plain compare
  always_comb begin
    if (state.previous_position == '0 && item.position == cfg.position_top) begin
      dir = erc_pkg::EV_DEC;
    end else if (state.previous_position == cfg.position_top &&
                 item.position == '0) begin
      dir = erc_pkg::EV_INC;
    end else if (item.position > state.previous_position) begin
      dir = erc_pkg::EV_INC;
    end else if (item.position < state.previous_position) begin
      dir = erc_pkg::EV_DEC;
    end else begin
      dir = erc_pkg::EV_NONE;
    end
  end

  always_comb begin
    dec.event_res  = erc_pkg::EV_NONE;
    dec.event_time = '0;
    dec.state_next = state;
    case (erc_pkg::cmd_t'(item.command))
      erc_pkg::CMD_POSITION: begin
        dec.event_res                    = dir;
        dec.state_next.previous_position = item.position;
      end
      erc_pkg::CMD_PRESS: begin
        if (!state.button_held && debounced) begin
          dec.event_res  = is_double ? erc_pkg::EV_DOUBLE : erc_pkg::EV_CLICK;
          dec.event_time = item.time_ms;
          dec.state_next.last_press_time = item.time_ms;
          dec.state_next.button_held     = 1'b1;
        end
      end
      erc_pkg::CMD_RELEASE: begin
        dec.state_next.last_release_time = item.time_ms;
        dec.state_next.button_held       = 1'b0;
      end
      erc_pkg::CMD_SYNC: begin
        if (state.button_held && item.button_level && debounced) begin
          dec.state_next.last_release_time = item.time_ms;
          dec.state_next.button_held       = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/encoder_rotation_and_click_detector_core.sv =====
// ============================================================================
// encoder_rotation_and_click_detector_core
// Rotary encoder direction and debounced click / double-click detector.
// ============================================================================
// Usage:
//   req carries one encoder event per request: a position update, a button
//   press, a release, or a sync with the sampled button level, each with a
//   millisecond timestamp. res returns exactly one result per request: none,
//   increment, decrement, click or double click, with the timestamp for
//   clicks and zero otherwise.
//   The APB port sets the counter top, debounce time and double-click window;
//   write it only while no request is in flight.
// Pipeline / throughput:
//   The request lands in the input register at the accepting edge, and the
//   decision logic then loads the result register from it. One request per
//   cycle is sustained while res does not stall; the decision is a pair of
//   32-bit subtracts and compares.
// Reset:
//   rst (synchronous) clears both pipeline stages, the previous position,
//   both timestamps and the held flag, and loads the register defaults.
// Backpressure:
//   While res is stalled the result register holds; one more request can sit
//   in the input register, after which req.ready drops until res drains.
// ============================================================================
module encoder_rotation_and_click_detector_core (
  input  logic                        clk,
  input  logic                        rst,
  erc_req_if.sink                     req,
  erc_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [erc_pkg::ADDR_W-1:0]  paddr,
  input  logic [erc_pkg::DATA_W-1:0]  pwdata,
  output logic [erc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  erc_pkg::cfg_t      cfg;
  erc_pkg::state_t    state;
  erc_pkg::item_t     s1_item;
  erc_pkg::decision_t dec;

  logic s1_valid;
  logic s1_ready;
  logic s2_ready;
  logic s1_fire;
  logic out_valid;

  erc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  erc_decide u_decide (
    .item  (s1_item),
    .state (state),
    .cfg   (cfg),
    .dec   (dec)
  );

  // result register frees when empty or being taken
  assign s2_ready  = !out_valid || res.ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign s1_fire   = s1_valid && s2_ready;
  assign req.ready = s1_ready;
  assign res.valid = out_valid;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && req.valid) begin
      s1_item.command      <= req.command;
      s1_item.position     <= req.position;
      s1_item.time_ms      <= req.time_ms;
      s1_item.button_level <= req.button_level;
    end
  end

  // detector state advances once per decided request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= dec.state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res.event_res  <= dec.event_res;
      res.event_time <= dec.event_time;
    end
  end

  // timestamp only travels with clicks
  a_time_only_on_click: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.event_res != erc_pkg::EV_CLICK &&
     res.event_res != erc_pkg::EV_DOUBLE) |-> (res.event_time == '0))
    else $error("nonzero event_time on non-click result");

  a_click_sets_held: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (dec.event_res == erc_pkg::EV_CLICK ||
                 dec.event_res == erc_pkg::EV_DOUBLE))
    |=> (state.button_held && state.last_press_time == $past(s1_item.time_ms)))
    else $error("click did not record press");

  a_release_clears_held: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_item.command == erc_pkg::CMD_RELEASE)
    |=> (!state.button_held && state.last_release_time == $past(s1_item.time_ms)))
    else $error("release did not clear held flag");

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the encoder rotation and click detector core. A
// scoreboard class predicts one result per accepted request from its own copy
// of the registers and the detector state. Each returned result is compared
// field by field against the oldest prediction. Stimulus: a directed set of
// wrap, debounce and double-click corners, then random event streams under
// several register settings. Both channels idle at random, with one long
// result hold-off.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import erc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;     // two-stage pipe plus margin
  localparam int unsigned LONG_HOLD    = 300;

  // --------------------------------------------------------------------------
  // Scoreboard: detector predictor plus the queue of predicted results
  // --------------------------------------------------------------------------
  class click_scoreboard;
    typedef struct packed {
      event_t      ev;
      logic [31:0] stamp;
    } outcome_t;

    cfg_t     cfg;
    state_t   st;
    outcome_t predicted_q[$];
    int       mismatches;
    int       result_count;

    function new();
      cfg.position_top    = POSITION_TOP_RESET;
      cfg.debounce_ms     = DEBOUNCE_MS_RESET;
      cfg.double_click_ms = DOUBLE_CLICK_MS_RESET;
      st                  = '0;
      mismatches          = 0;
      result_count        = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_POSITION_TOP:    cfg.position_top    = value[POS_W-1:0];
        REG_DEBOUNCE_MS:     cfg.debounce_ms     = value[DBNC_W-1:0];
        REG_DOUBLE_CLICK_MS: cfg.double_click_ms = value[DCLK_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction

    // press / sync only count once both timestamps are far enough back
    function bit debounce_ok(logic [31:0] now);
      logic [31:0] since_press;
      logic [31:0] since_release;
      since_press   = now - st.last_press_time;
      since_release = now - st.last_release_time;
      return (since_press > {24'd0, cfg.debounce_ms}) &&
             (since_release > {24'd0, cfg.debounce_ms});
    endfunction

    // wrap checks come first, so with top zero a 0 -> 0 step is a decrement
    function event_t rotation(logic [15:0] prev, logic [15:0] now);
      if (prev == 16'd0 && now == cfg.position_top) return EV_DEC;
      if (prev == cfg.position_top && now == 16'd0) return EV_INC;
      if (now > prev) return EV_INC;
      if (now < prev) return EV_DEC;
      return EV_NONE;
    endfunction

    function void note_request(item_t it);
      outcome_t    o;
      logic [31:0] now;
      logic [31:0] since_press;
      o.ev    = EV_NONE;
      o.stamp = '0;
      now     = it.time_ms;
      case (cmd_t'(it.command))
        CMD_POSITION: begin
          o.ev = rotation(st.previous_position, it.position);
          st.previous_position = it.position;
        end
        CMD_PRESS: begin
          if (!st.button_held && debounce_ok(now)) begin
            since_press        = now - st.last_press_time;
            o.ev               = (since_press < {16'd0, cfg.double_click_ms}) ?
                                 EV_DOUBLE : EV_CLICK;
            o.stamp            = now;
            st.last_press_time = now;
            st.button_held     = 1'b1;
          end
        end
        CMD_RELEASE: begin
          st.last_release_time = now;
          st.button_held       = 1'b0;
        end
        default: begin
          if (st.button_held && it.button_level && debounce_ok(now)) begin
            st.last_release_time = now;
            st.button_held       = 1'b0;
          end
        end
      endcase
      predicted_q.push_back(o);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: result %0d: %s", result_count, msg);
    endtask

    task check_result(logic [2:0] ev, logic [31:0] stamp);
      outcome_t want;
      if (predicted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result ev=%0d time=%h", ev, stamp));
      end else begin
        want = predicted_q.pop_front();
        if (ev !== want.ev)
          report_mismatch($sformatf("event_res %0d, want %0d", ev, want.ev));
        if (stamp !== want.stamp)
          report_mismatch($sformatf("event_time %h, want %h", stamp, want.stamp));
      end
      result_count++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  erc_req_if req_ch ();
  erc_res_if res_ch ();

  click_scoreboard sb;

  // knobs shared between the main sequence and the result side
  bit          sender_fast   = 1'b0;   // no gaps between requests
  bit          receiver_fast = 1'b0;   // no stalls on the result side
  int unsigned hold_request  = 0;      // one-shot long hold-off, in cycles
  logic [31:0] clock_ms;               // running timestamp for random events
  int unsigned cycle_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  encoder_rotation_and_click_detector_core uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle held until pready
  task automatic write_register(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // One request. valid only drops when a gap is drawn, so back-to-back
  // requests never see a low/high pair in the same time step.
  task automatic send_event(cmd_t cmd, logic [15:0] pos, logic [31:0] t, logic level);
    item_t       it;
    int unsigned gap;
    it.command      = cmd;
    it.position     = pos;
    it.time_ms      = t;
    it.button_level = level;
    gap = sender_fast ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= it.command;
    req_ch.position     <= it.position;
    req_ch.time_ms      <= it.time_ms;
    req_ch.button_level <= it.button_level;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(it);
  endtask

  // Random event with well-formed timing most of the time: steps around the
  // debounce and double-click windows, plus the odd jump or backwards time.
  task automatic send_random();
    cmd_t        cmd;
    logic [15:0] pos;
    logic [15:0] prev;
    logic [15:0] top;
    int unsigned pick;
    int unsigned dbn;
    int unsigned dcw;
    pick = $urandom_range(0, 99);
    if (pick < 40)      cmd = CMD_POSITION;
    else if (pick < 65) cmd = CMD_PRESS;
    else if (pick < 80) cmd = CMD_RELEASE;
    else                cmd = CMD_SYNC;

    dbn  = sb.cfg.debounce_ms;
    dcw  = sb.cfg.double_click_ms;
    pick = $urandom_range(0, 99);
    if (pick < 45)      clock_ms += $urandom_range(0, dbn + 4);
    else if (pick < 90) clock_ms += $urandom_range(0, dcw + 64);
    else if (pick < 97) clock_ms += $urandom;
    else                clock_ms  = $urandom;

    prev = sb.st.previous_position;
    top  = sb.cfg.position_top;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 1)) pos = prev + 16'($urandom_range(1, 3));
      else                      pos = prev - 16'($urandom_range(1, 3));
    end else if (pick < 60) begin
      pos = prev;
    end else if (pick < 80) begin
      // wrap across the counter top
      if (prev == 16'd0)      pos = top;
      else if (prev == top)   pos = 16'd0;
      else                    pos = $urandom_range(0, 1) ? 16'd0 : top;
    end else begin
      pos = 16'($urandom);
    end
    send_event(cmd, pos, clock_ms, 1'($urandom_range(0, 1)));
  endtask

  // Idle point: every prediction met, then a drain wait for the pipe
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall before each result, one long hold when asked
  // --------------------------------------------------------------------------
  initial begin : result_side
    int unsigned stall;
    res_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = receiver_fast ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      sb.check_result(res_ch.event_res, res_ch.event_time);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int phase;
    int k;
    sb                  = new();
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_POSITION;
    req_ch.position     = '0;
    req_ch.time_ms      = '0;
    req_ch.button_level = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed corners under reset defaults (top 65532, 50 ms, 300 ms)
    send_event(CMD_POSITION, 16'd5,     32'd0,    1'b1);  // up from zero
    send_event(CMD_POSITION, 16'd5,     32'd0,    1'b0);  // no move
    send_event(CMD_POSITION, 16'd3,     32'd0,    1'b1);  // down
    send_event(CMD_POSITION, 16'd0,     32'd0,    1'b0);
    send_event(CMD_POSITION, 16'd65532, 32'd0,    1'b1);  // wrap 0 -> top: down
    send_event(CMD_POSITION, 16'd0,     32'd0,    1'b0);  // wrap top -> 0: up
    send_event(CMD_POSITION, 16'hFFFF,  32'd0,    1'b1);  // max above top
    send_event(CMD_POSITION, 16'd0,     32'd0,    1'b0);  // not a wrap: down
    send_event(CMD_PRESS,    16'hFFFF,  32'd1000, 1'b1);  // click
    send_event(CMD_PRESS,    16'h0000,  32'd1100, 1'b0);  // held: ignored
    send_event(CMD_RELEASE,  16'hFFFF,  32'd1200, 1'b1);
    send_event(CMD_PRESS,    16'h0000,  32'd1230, 1'b0);  // too soon after release
    send_event(CMD_PRESS,    16'hFFFF,  32'd1290, 1'b1);  // double click
    send_event(CMD_SYNC,     16'h0000,  32'd1500, 1'b0);  // pressed level: stays held
    send_event(CMD_SYNC,     16'hFFFF,  32'd1300, 1'b1);  // not debounced
    send_event(CMD_SYNC,     16'h0000,  32'd1500, 1'b1);  // debounced release
    send_event(CMD_PRESS,    16'hFFFF,  32'd1540, 1'b0);  // too soon after sync
    send_event(CMD_RELEASE,  16'h0000,  32'd1600, 1'b1);  // release while not held
    send_event(CMD_SYNC,     16'hFFFF,  32'd5000, 1'b1);  // sync while not held
    send_event(CMD_PRESS,    16'h0000,  32'hFFFF_FFF0, 1'b0);  // click near wrap
    send_event(CMD_RELEASE,  16'hFFFF,  32'h0000_0010, 1'b1);  // time wraps
    send_event(CMD_PRESS,    16'h0000,  32'h0000_0050, 1'b0);  // double across wrap
    send_event(CMD_SYNC,     16'hFFFF,  32'hFFFF_FFFF, 1'b1);  // backwards in time
    send_event(CMD_RELEASE,  16'h0000,  32'hFFFF_FFFF, 1'b0);
    req_ch.valid <= 1'b0;

    // ---- random phases, each under its own register setting
    for (phase = 1; phase <= 6; phase++) begin
      wait_drained();
      case (phase)
        1: begin
          write_register(REG_POSITION_TOP,    32'd1);
          write_register(REG_DEBOUNCE_MS,     32'd0);
          write_register(REG_DOUBLE_CLICK_MS, 32'd0);
        end
        2: begin
          write_register(REG_POSITION_TOP,    32'd65535);
          write_register(REG_DEBOUNCE_MS,     32'd255);
          write_register(REG_DOUBLE_CLICK_MS, 32'd65535);
        end
        3: begin
          // top zero: a 0 -> 0 step hits the wrap check first
          write_register(REG_POSITION_TOP,    32'd0);
          write_register(REG_DEBOUNCE_MS,     32'd50);
          write_register(REG_DOUBLE_CLICK_MS, 32'd300);
        end
        4: begin
          // junk above each field, plus a write to the unused slot
          write_register(REG_POSITION_TOP,    {16'($urandom), 16'($urandom_range(1, 65535))});
          write_register(REG_DEBOUNCE_MS,     {24'($urandom), 8'($urandom)});
          write_register(REG_DOUBLE_CLICK_MS, {16'($urandom), 16'($urandom_range(0, 2000))});
          write_register(REG_UNUSED,          $urandom);
        end
        5: begin
          write_register(REG_POSITION_TOP,    32'd100);
          write_register(REG_DEBOUNCE_MS,     32'd10);
          write_register(REG_DOUBLE_CLICK_MS, 32'd500);
        end
        default: begin
          write_register(REG_POSITION_TOP,    $urandom_range(1, 65535));
          write_register(REG_DEBOUNCE_MS,     $urandom_range(0, 255));
          write_register(REG_DOUBLE_CLICK_MS, $urandom_range(0, 65535));
        end
      endcase
      clock_ms = $urandom;

      if (phase == 3) begin
        send_event(CMD_POSITION, 16'd0, clock_ms, 1'b0);
        send_event(CMD_POSITION, 16'd0, clock_ms, 1'b1);
      end

      if (phase == 2) begin
        // long result hold-off while requests keep coming: pipe fills,
        // req.ready must drop and recover without losing anything
        hold_request = LONG_HOLD;
        sender_fast  = 1'b1;
        for (k = 0; k < 40; k++) send_random();
        sender_fast  = 1'b0;
      end

      for (k = 0; k < 110; k++) begin
        // a stretch with no idling on either side
        if (phase == 4 && k == 30) begin
          sender_fast   = 1'b1;
          receiver_fast = 1'b1;
        end
        if (phase == 4 && k == 70) begin
          sender_fast   = 1'b0;
          receiver_fast = 1'b0;
        end
        send_random();
      end
      req_ch.valid <= 1'b0;
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
